@@ rtl/fbds_pkg.sv @@
// shared constants and types for the fractional baud divisor search
// no dependencies
`default_nettype none
package fbds_pkg;
    localparam int unsigned SCALE_LIMIT = 7;
    localparam logic [31:0] SCORE_UNIT  = 32'd10000;
    localparam logic [31:0] DIV_LIMIT   = 32'd4095;
    localparam logic [15:0] SCORE_INIT  = 16'hFFFF;
    localparam logic [13:0] TOL_RESET   = 14'd200;

    // divider operations, one per candidate step
    typedef enum logic [1:0] {
        OP_QUOT,
        OP_ACH,
        OP_SCORE
    } t_op;
endpackage
`default_nettype wire

@@ rtl/fractional_baud_divisor_search.sv @@
// fractional baud divisor search: sequencer around one shared serial divider
// depends on fbds_pkg
// the divider yields one quotient bit a cycle; each candidate runs a 32-bit quotient division and,
// if it qualifies, a 32-bit achieved-rate division and the 48-bit score division; up to 15
// candidates a pass and up to two passes run between the start transfer and the result strobe
// throughput: one item at a time; busy is high from the start transfer until the strobe rises
// the result is shown on o_valid for one cycle; the receiver cannot stall it
// reset (synchronous, active low) returns to idle and sets the tolerance to 200
`default_nettype none
module fractional_baud_divisor_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [24:0] i_peripheral_clock,
    input  wire logic [23:0] i_target_baud,
    input  wire logic        i_cfg_we,
    input  wire logic [13:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [11:0]      o_divisor,
    output logic signed [3:0] o_scale_exponent,
    output logic             o_double_speed,
    output logic [15:0]      o_deviation,
    output logic             o_found
);
    typedef enum logic [3:0] {
        S_IDLE, S_PASS, S_POS, S_NEG_INIT, S_NEG, S_DIV, S_DIV_DONE, S_CONSIDER,
        S_PASS_END, S_OUT
    } t_state;

    t_state r_state;
    logic [13:0] r_tol;
    logic [24:0] r_clk;
    logic [23:0] r_baud;
    logic        r_dbl;
    logic        r_neg;
    logic [2:0]  r_s;
    logic [31:0] r_den;
    logic [31:0] r_q;
    fbds_pkg::t_op r_op;
    // best of current pass
    logic [11:0] r_bdiv;
    logic signed [3:0] r_bscale;
    logic [15:0] r_bscore;
    logic        r_bfound;
    // best of first pass
    logic [11:0] r_fdiv;
    logic signed [3:0] r_fscale;
    logic [15:0] r_fscore;
    logic        r_ffound;
    // serial divider: 48-bit dividend for the score division
    logic [47:0] r_dvd;
    logic [31:0] r_dvs;
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;

    logic [2:0]  fshift;
    logic [32:0] rem_sh;
    logic [31:0] clk32, baud32, den_p, diff_p, den_n, num_n;
    logic [2:0]  s_next;

    always_comb begin
        fshift  = r_dbl ? 3'd3 : 3'd4;
        clk32   = {7'd0, r_clk};
        baud32  = {8'd0, r_baud};
        den_p   = baud32 << ({1'b0, fshift} + {1'b0, r_s});
        diff_p  = (clk32 << 1) - den_p;
        den_n   = baud32 << (fshift - 3'd1);
        num_n   = ((clk32 - (den_n << 1)) << r_s) + den_n;
        rem_sh  = {r_rem[31:0], r_dvd[6'd47 - r_cnt]};
        s_next  = r_s + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tol   <= fbds_pkg::TOL_RESET;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) r_tol <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_clk   <= i_peripheral_clock;
                        r_baud  <= i_target_baud;
                        r_dbl   <= 1'b0;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_bdiv <= '0; r_bscale <= '0;
                    r_bscore <= fbds_pkg::SCORE_INIT; r_bfound <= 1'b0;
                    r_s <= '0; r_neg <= 1'b0;
                    r_state <= S_POS;
                end
                S_POS: begin
                    if (diff_p == 32'd0 || diff_p[31]) begin
                        r_state <= S_NEG_INIT;
                    end else begin
                        r_den <= den_p;
                        r_dvd <= {16'd0, diff_p}; r_dvs <= den_p << 1;
                        r_op <= fbds_pkg::OP_QUOT;
                        r_cnt <= 6'd16; r_rem <= '0; r_quo <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_NEG_INIT: begin
                    r_s <= 3'd1; r_neg <= 1'b1;
                    r_den <= den_n;
                    r_state <= (clk32 >= (den_n << 1)) ? S_NEG : S_PASS_END;
                end
                S_NEG: begin
                    r_dvd <= {16'd0, num_n}; r_dvs <= r_den << 1;
                    r_op <= fbds_pkg::OP_QUOT;
                    r_cnt <= 6'd16; r_rem <= '0; r_quo <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    if (rem_sh >= {1'b0, r_dvs}) begin
                        r_rem <= rem_sh - {1'b0, r_dvs};
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    if (r_cnt == 6'd47) r_state <= S_DIV_DONE;
                    r_cnt <= r_cnt + 6'd1;
                end
                S_DIV_DONE: begin
                    unique case (r_op)
                        fbds_pkg::OP_QUOT: begin
                            logic [31:0] qv;
                            qv = (r_dvs == 32'd0) ? 32'hFFFF_FFFF : r_quo[31:0];
                            r_q <= qv;
                            if (qv >= fbds_pkg::DIV_LIMIT) begin
                                if (r_neg) r_state <= S_PASS_END;
                                else if (r_s == 3'(fbds_pkg::SCALE_LIMIT)) r_state <= S_NEG_INIT;
                                else begin r_s <= s_next; r_state <= S_POS; end
                            end else begin
                                r_dvd <= {16'd0, r_neg ? (clk32 << r_s) : (clk32 >> r_s)};
                                r_dvs <= r_neg ? ((qv + (32'd1 << r_s)) << fshift)
                                               : ((qv + 32'd1) << fshift);
                                r_op <= fbds_pkg::OP_ACH;
                                r_cnt <= 6'd16; r_rem <= '0; r_quo <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        fbds_pkg::OP_ACH: begin
                            logic [31:0] av;
                            av = (r_dvs == 32'd0) ? 32'hFFFF_FFFF : r_quo[31:0];
                            if (av == 32'd0 || r_baud == 24'd0) begin
                                r_state <= S_CONSIDER;
                                r_op <= fbds_pkg::OP_ACH;
                            end else begin
                                if (baud32 < av) begin
                                    r_dvd <= {16'd0, av} * 48'd10000; r_dvs <= baud32;
                                end else begin
                                    r_dvd <= {24'd0, r_baud} * 48'd10000; r_dvs <= av;
                                end
                                r_op <= fbds_pkg::OP_SCORE;
                                r_cnt <= 6'd0; r_rem <= '0; r_quo <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            if (r_quo[15:0] < r_bscore) begin
                                r_bscore <= r_quo[15:0];
                                r_bdiv <= r_q[11:0];
                                r_bscale <= r_neg ? -$signed({1'b0, r_s}) : $signed({1'b0, r_s});
                                r_bfound <= 1'b1;
                            end
                            r_state <= S_CONSIDER;
                        end
                    endcase
                end
                S_CONSIDER: begin
                    // next scale
                    if (r_s == 3'(fbds_pkg::SCALE_LIMIT))
                        r_state <= r_neg ? S_PASS_END : S_NEG_INIT;
                    else begin
                        r_s <= s_next;
                        r_state <= r_neg ? S_NEG : S_POS;
                    end
                end
                S_PASS_END: begin
                    if (!r_dbl) begin
                        r_fdiv <= r_bdiv; r_fscale <= r_bscale;
                        r_fscore <= r_bscore; r_ffound <= r_bfound;
                        if ({16'd0, r_bscore} > fbds_pkg::SCORE_UNIT + {18'd0, r_tol}) begin
                            r_dbl <= 1'b1;
                            r_state <= S_PASS;
                        end else begin
                            r_dbl <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        if (!r_bfound) begin
                            r_bdiv <= r_fdiv; r_bscale <= r_fscale;
                            r_bscore <= r_fscore; r_bfound <= r_ffound;
                            r_dbl <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_divisor <= r_bdiv;
                    o_scale_exponent <= r_bscale;
                    o_double_speed <= r_dbl;
                    o_deviation <= r_bscore - fbds_pkg::SCORE_UNIT[15:0];
                    o_found <= r_bfound;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_found_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_deviation == 16'd55535 && o_divisor == 12'd0))
        else $error("empty result not cleared");
`endif
endmodule
`default_nettype wire
